// ----- hdl/wsd_pkg.sv -----
// Shared constants and result codes for the WebSocket frame deframer.
package wsd_pkg;

	localparam int unsigned MAXP_WIDTH = 25;
	localparam int unsigned LEN_WIDTH  = 64;

	localparam logic [MAXP_WIDTH-1:0] MAXP_RESET = 25'd16777216;

	localparam logic [7:0] RSV_MASK    = 8'h70;
	localparam logic [7:0] FIN_BIT     = 8'h80;
	localparam logic [7:0] LEN7_MASK   = 8'h7f;
	localparam logic [3:0] CTRL_BIT    = 4'h8;
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;
	localparam logic [6:0] CTRL_MAXLEN = 7'd125;

	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_PAYLOAD = 2'd0;
	localparam kind_t KIND_EMPTY   = 2'd1;
	localparam kind_t KIND_ERROR   = 2'd2;

endpackage

// ----- hdl/wsd_in_if.sv -----
// Byte stream channel into the deframer.
interface wsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/wsd_out_if.sv -----
// Result channel out of the deframer.
interface wsd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] payload_byte;
	logic [3:0] frame_opcode;
	logic       frame_final;
	logic       last_of_frame;

	modport source (output valid, output out_kind, output payload_byte, output frame_opcode,
		output frame_final, output last_of_frame, input ready);
	modport sink   (input valid, input out_kind, input payload_byte, input frame_opcode,
		input frame_final, input last_of_frame, output ready);
endinterface

// ----- hdl/websocket_frame_deframer.sv -----
// An accepted byte enters the input register; its result, if any, the result register.
// Throughput: one byte per cycle unless stalled; parser state sits between those registers.
// A stalled result register holds the input register, which in turn drops ready.
// Reset (arst_n, asynchronous, active low) returns the parser to the first header byte
// and max_payload to 16 MiB; a protocol error is sticky until the next reset.
module websocket_frame_deframer
	import wsd_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [MAXP_WIDTH-1:0] cfg_wdata,
	wsd_in_if.sink                stream,
	wsd_out_if.source             result
);

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT,
		PH_KEY,
		PH_DATA,
		PH_ERR
	} phase_t;

	phase_t                 phase_q, phase_n;
	logic [3:0]             opcode_q, opcode_n;
	logic                   final_q, final_n;
	logic [LEN_WIDTH-1:0]   len_q, len_n;
	logic [3:0]             cnt_q, cnt_n;
	logic [31:0]            key_q, key_n;
	logic [1:0]             pos_q, pos_n;
	logic [COUNT_WIDTH-1:0] left_q, left_n;
	logic [MAXP_WIDTH-1:0]  maxp_q;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_byte_q;
	logic [3:0] out_op_q;
	logic       out_fin_q;
	logic       out_last_q;

	logic       adv, work;
	logic       emit, raise_err, len_done, len_bad;
	kind_t      kind_n;
	logic [7:0] data_n, key_byte;
	logic       last_n;

	assign adv          = !out_valid_q || result.ready;
	assign work         = valid_s1 && adv;
	assign stream.ready = !valid_s1 || adv;

	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n   = phase_q;
		opcode_n  = opcode_q;
		final_n   = final_q;
		len_n     = len_q;
		cnt_n     = cnt_q;
		key_n     = key_q;
		pos_n     = pos_q;
		left_n    = left_q;
		emit      = 1'b0;
		raise_err = 1'b0;
		len_done  = 1'b0;
		kind_n    = KIND_PAYLOAD;
		data_n    = 8'd0;
		last_n    = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				opcode_n = byte_s1[3:0];
				final_n  = (byte_s1 & FIN_BIT) != 8'd0;
				if ((byte_s1 & RSV_MASK) != 8'd0) begin
					raise_err = 1'b1;
				end else begin
					phase_n = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if ((byte_s1 & FIN_BIT) == 8'd0) begin
					raise_err = 1'b1;
				end else if (byte_s1[6:0] == LEN7_EXT16) begin
					len_n   = '0;
					cnt_n   = EXT16_BYTES;
					phase_n = PH_EXT;
				end else if (byte_s1[6:0] == LEN7_EXT64) begin
					len_n   = '0;
					cnt_n   = EXT64_BYTES;
					phase_n = PH_EXT;
				end else begin
					len_n    = LEN_WIDTH'(byte_s1 & LEN7_MASK);
					len_done = 1'b1;
				end
			end
			PH_EXT: begin
				len_n = {len_q[LEN_WIDTH-9:0], byte_s1};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					len_done = 1'b1;
				end
			end
			PH_KEY: begin
				key_n = {key_q[23:0], byte_s1};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					pos_n = 2'd0;
					if (left_q == '0) begin
						phase_n = PH_HDR0;
						emit    = 1'b1;
						kind_n  = KIND_EMPTY;
						last_n  = 1'b1;
					end else begin
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				pos_n  = pos_q + 2'd1;
				left_n = left_q - COUNT_WIDTH'(1);
				last_n = left_n == '0;
				emit   = 1'b1;
				kind_n = KIND_PAYLOAD;
				data_n = byte_s1 ^ key_byte;
				if (last_n) begin
					phase_n = PH_HDR0;
				end
			end
			PH_ERR: begin
				phase_n = PH_ERR;
			end
			default: begin
				phase_n = PH_ERR;
			end
		endcase
		// over max_payload, too wide for the counter, or an oversized or fragmented control frame
		len_bad = (|(len_n >> MAXP_WIDTH)) || (len_n[MAXP_WIDTH-1:0] > maxp_q)
			|| (|(len_n >> COUNT_WIDTH))
			|| (((opcode_n & CTRL_BIT) != 4'd0)
				&& ((len_n > LEN_WIDTH'(CTRL_MAXLEN)) || !final_n));
		if (len_done) begin
			if (len_bad) begin
				raise_err = 1'b1;
			end else begin
				left_n  = len_n[COUNT_WIDTH-1:0];
				key_n   = '0;
				pos_n   = 2'd0;
				cnt_n   = KEY_BYTES;
				phase_n = PH_KEY;
			end
		end
		if (raise_err) begin
			phase_n = PH_ERR;
			emit    = 1'b1;
			kind_n  = KIND_ERROR;
			data_n  = 8'd0;
			last_n  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HDR0;
			opcode_q    <= '0;
			final_q     <= 1'b0;
			len_q       <= '0;
			cnt_q       <= '0;
			key_q       <= '0;
			pos_q       <= '0;
			left_q      <= '0;
			maxp_q      <= MAXP_RESET;
			valid_s1    <= 1'b0;
			byte_s1     <= '0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_PAYLOAD;
			out_byte_q  <= '0;
			out_op_q    <= '0;
			out_fin_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				maxp_q <= cfg_wdata;
			end
			if (stream.valid && stream.ready) begin
				valid_s1 <= 1'b1;
				byte_s1  <= stream.rx_byte;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (work) begin
				phase_q  <= phase_n;
				opcode_q <= opcode_n;
				final_q  <= final_n;
				len_q    <= len_n;
				cnt_q    <= cnt_n;
				key_q    <= key_n;
				pos_q    <= pos_n;
				left_q   <= left_n;
			end
			if (adv) begin
				out_valid_q <= work && emit;
			end
			if (work && emit) begin
				out_kind_q <= kind_n;
				out_byte_q <= data_n;
				out_op_q   <= opcode_n;
				out_fin_q  <= final_n;
				out_last_q <= last_n;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_kind      = out_kind_q;
	assign result.payload_byte  = out_byte_q;
	assign result.frame_opcode  = out_op_q;
	assign result.frame_final   = out_fin_q;
	assign result.last_of_frame = out_last_q;

`ifndef SYNTH
	// error state is sticky
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERR |=> phase_q == PH_ERR)
		else $error("left error state before reset");

	// entering the error state always presents an error word
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ERR) ##1 (phase_q == PH_ERR) |-> out_valid_q && out_kind_q == KIND_ERROR)
		else $error("error state entered without error word");

	// a stalled input word is held, not lost
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a word under stall");

	// error and empty-frame words always close the frame
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_kind_q == KIND_ERROR || out_kind_q == KIND_EMPTY) |-> out_last_q)
		else $error("error or empty word without last mark");
`endif

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for the WebSocket frame deframer: directed frames, random frames, one final error.
`timescale 1ns / 100ps

module tb_top
	import wsd_pkg::*;
();

	localparam int unsigned CNT_W = 25;
	localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;

	typedef enum logic [2:0] {ST_HDR0, ST_HDR1, ST_EXT, ST_KEY, ST_DATA, ST_ERR} parse_st_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [3:0] opcode;
		logic       fin;
		logic       last;
	} word_res_t;

	typedef struct packed {
		bit        pinned;
		bit        has;
		word_res_t res;
	} word_tag_t;

	typedef struct packed {
		logic [7:0] data;
		bit         pinned;
		bit         has;
		word_res_t  res;
	} row_t;

	localparam word_res_t NO_RES = '0;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [MAXP_WIDTH-1:0] cfg_wdata;

	wsd_in_if  stream_if();
	wsd_out_if result_if();

	websocket_frame_deframer #(
		.COUNT_WIDTH(CNT_W)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.stream   (stream_if),
		.result   (result_if)
	);

	// parser shadow state
	parse_st_t             hdr_phase  = ST_HDR0;
	logic [3:0]            hdr_opcode = '0;
	logic                  hdr_final  = 1'b0;
	logic [63:0]           len_acc    = '0;
	logic [3:0]            bytes_left = '0;
	logic [31:0]           key_word   = '0;
	logic [1:0]            key_idx    = '0;
	logic [CNT_W-1:0]      body_left  = '0;
	logic                  err_seen   = 1'b0;
	logic [MAXP_WIDTH-1:0] max_len    = MAXP_RESET;

	word_res_t due_q[$];
	word_tag_t pin_q[$];
	int        fail_cnt   = 0;
	int        burst_left = 0;
	int        words_sent = 0;
	bit        valid_up   = 1'b0;

	// header frames: empty text, 16-bit length with zero key, masked pong
	row_t dir_rows [25] = '{
		'{8'h81, 1'b1, 1'b0, NO_RES},
		'{8'h80, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, '{KIND_EMPTY, 8'h00, 4'h1, 1'b1, 1'b1}},
		'{8'h02, 1'b1, 1'b0, NO_RES},
		'{8'hFE, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h02, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'hFF, 4'h2, 1'b0, 1'b0}},
		'{8'h00, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, 4'h2, 1'b0, 1'b1}},
		'{8'h8A, 1'b0, 1'b0, NO_RES},
		'{8'h83, 1'b0, 1'b0, NO_RES},
		'{8'h12, 1'b0, 1'b0, NO_RES},
		'{8'h34, 1'b0, 1'b0, NO_RES},
		'{8'h56, 1'b0, 1'b0, NO_RES},
		'{8'h78, 1'b0, 1'b0, NO_RES},
		'{8'hF0, 1'b0, 1'b0, NO_RES},
		'{8'h0F, 1'b0, 1'b0, NO_RES},
		'{8'hAA, 1'b0, 1'b0, NO_RES}
	};

	function automatic word_res_t pack_res(input kind_t kind, input logic [7:0] data,
		input logic last);
		pack_res = '{kind, data, hdr_opcode, hdr_final, last};
	endfunction

	function automatic bit flag_error(output word_res_t r);
		err_seen  = 1'b1;
		hdr_phase = ST_ERR;
		r = pack_res(KIND_ERROR, 8'h00, 1'b1);
		return 1'b1;
	endfunction

	// length is complete: validate, then collect the masking key
	function automatic bit check_length(output word_res_t r);
		r = NO_RES;
		if (len_acc > {39'd0, max_len} || len_acc > CNT_MAX)
			return flag_error(r);
		if ((hdr_opcode & CTRL_BIT) != 4'h0 && (len_acc > {57'd0, CTRL_MAXLEN} || !hdr_final))
			return flag_error(r);
		body_left  = len_acc[CNT_W-1:0];
		key_word   = '0;
		key_idx    = '0;
		bytes_left = KEY_BYTES;
		hdr_phase  = ST_KEY;
		return 1'b0;
	endfunction

	function automatic bit deframe_step(input logic [7:0] b, output word_res_t r);
		logic [6:0] l7;
		logic       last;
		r = NO_RES;
		if (err_seen || hdr_phase == ST_ERR) begin
			err_seen  = 1'b1;
			hdr_phase = ST_ERR;
			return 1'b0;
		end
		case (hdr_phase)
			ST_HDR0: begin
				hdr_opcode = b[3:0];
				hdr_final  = b[7];
				if ((b & RSV_MASK) != 8'h00)
					return flag_error(r);
				hdr_phase = ST_HDR1;
				return 1'b0;
			end
			ST_HDR1: begin
				l7 = b[6:0];
				if ((b & FIN_BIT) == 8'h00)
					return flag_error(r);
				len_acc = '0;
				if (l7 == LEN7_EXT16) begin
					bytes_left = EXT16_BYTES;
					hdr_phase  = ST_EXT;
					return 1'b0;
				end
				if (l7 == LEN7_EXT64) begin
					bytes_left = EXT64_BYTES;
					hdr_phase  = ST_EXT;
					return 1'b0;
				end
				len_acc = {57'd0, l7};
				return check_length(r);
			end
			ST_EXT: begin
				len_acc    = {len_acc[55:0], b};
				bytes_left = bytes_left - 4'd1;
				if (bytes_left == 4'd0)
					return check_length(r);
				return 1'b0;
			end
			ST_KEY: begin
				key_word   = {key_word[23:0], b};
				bytes_left = bytes_left - 4'd1;
				if (bytes_left != 4'd0)
					return 1'b0;
				key_idx = '0;
				if (body_left == '0) begin
					hdr_phase = ST_HDR0;
					r = pack_res(KIND_EMPTY, 8'h00, 1'b1);
					return 1'b1;
				end
				hdr_phase = ST_DATA;
				return 1'b0;
			end
			ST_DATA: begin
				r.data    = b ^ key_word[8*(3-key_idx) +: 8];
				key_idx   = key_idx + 2'd1;
				body_left = body_left - CNT_W'(1);
				last      = body_left == '0;
				if (last)
					hdr_phase = ST_HDR0;
				r = pack_res(KIND_PAYLOAD, r.data, last);
				return 1'b1;
			end
			default: begin
				err_seen  = 1'b1;
				hdr_phase = ST_ERR;
				return 1'b0;
			end
		endcase
	endfunction

	task automatic note_fail(input string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("[%0t] %s", $realtime, msg);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver stall pattern: steady, mostly ready, one in four, mostly stalled
	logic       rx_ready  = 1'b0;
	logic [9:0] stall_ctr = '0;
	assign result_if.ready = rx_ready;

	always @(posedge clk) begin
		stall_ctr <= stall_ctr + 10'd1;
		case (stall_ctr[9:8])
			2'd0: rx_ready <= 1'b1;
			2'd1: rx_ready <= $urandom_range(0, 9) < 7;
			2'd2: rx_ready <= stall_ctr[1:0] == 2'd0;
			default: rx_ready <= $urandom_range(0, 9) < 3;
		endcase
	end

	// input side: predict each accepted word
	always @(posedge clk) begin
		word_tag_t tag;
		word_res_t want;
		bit        hit;
		if (arst_n && stream_if.valid && stream_if.ready) begin
			tag = pin_q.pop_front();
			hit = deframe_step(stream_if.rx_byte, want);
			if (tag.pinned) begin
				hit  = tag.has;
				want = tag.res;
			end
			if (hit)
				due_q = {due_q, want};
		end
	end

	// output side: compare against the oldest expectation
	always @(posedge clk) begin
		word_res_t got;
		word_res_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = '{result_if.out_kind, result_if.payload_byte, result_if.frame_opcode,
				result_if.frame_final, result_if.last_of_frame};
			if (due_q.size() == 0) begin
				note_fail($sformatf("unexpected result kind %0d byte %h", got.kind, got.data));
			end else begin
				want = due_q.pop_front();
				if (got.kind !== want.kind || got.data !== want.data ||
					got.opcode !== want.opcode || got.fin !== want.fin ||
					got.last !== want.last)
					note_fail($sformatf(
						"mismatch exp kind %0d byte %h op %h fin %b last %b, got %0d %h %h %b %b",
						want.kind, want.data, want.opcode, want.fin, want.last,
						got.kind, got.data, got.opcode, got.fin, got.last));
			end
		end
	end

	task automatic push_word(input logic [7:0] b, input word_tag_t tag);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap != 0) begin
				if (valid_up)
					stream_if.valid <= 1'b0;
				valid_up = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		stream_if.valid   <= 1'b1;
		stream_if.rx_byte <= b;
		valid_up = 1'b1;
		pin_q = {pin_q, tag};
		do @(posedge clk); while (!stream_if.ready);
		burst_left--;
		words_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		push_word(b, '{1'b0, 1'b0, NO_RES});
	endtask

	// hold the sender until every expected word is back and the pipe has drained
	task automatic settle();
		int waited;
		waited = 0;
		if (valid_up)
			stream_if.valid <= 1'b0;
		valid_up = 1'b0;
		while ((due_q.size() != 0 || pin_q.size() != 0) && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		if (due_q.size() != 0)
			note_fail($sformatf("%0d results never arrived", due_q.size()));
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_payload(input logic [MAXP_WIDTH-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		max_len = v;
	endtask

	task automatic send_len(input int unsigned enc, input logic [63:0] len64);
		if (enc == 1)
			for (int i = 1; i >= 0; i--) send_byte(len64[8*i +: 8]);
		if (enc == 2)
			for (int i = 7; i >= 0; i--) send_byte(len64[8*i +: 8]);
	endtask

	task automatic send_frame();
		logic [3:0]  op;
		logic        fin;
		logic [31:0] key;
		int unsigned lim;
		int unsigned len;
		int unsigned enc;
		op  = 4'($urandom_range(0, 15));
		fin = op[3] ? 1'b1 : 1'($urandom_range(0, 1));
		lim = max_len;
		if (op[3] && lim > 125)
			lim = 125;
		if (lim == 0 || $urandom_range(0, 5) == 0)
			len = 0;
		else if (lim <= 300 && $urandom_range(0, 3) == 0)
			len = lim;
		else if ($urandom_range(0, 11) == 0)
			len = $urandom_range(1, (lim < 300) ? lim : 300);
		else
			len = $urandom_range(1, (lim < 24) ? lim : 24);
		if (len > 125)
			enc = ($urandom_range(0, 3) == 0) ? 2 : 1;
		else
			enc = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 2);
		case ($urandom_range(0, 7))
			0: key = '0;
			1: key = '1;
			default: key = $urandom;
		endcase
		send_byte({fin, 3'b000, op});
		send_byte({1'b1, (enc == 0) ? 7'(len) : (enc == 1) ? LEN7_EXT16 : LEN7_EXT64});
		send_len(enc, 64'(len));
		for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
		repeat (len) send_byte(8'($urandom));
	endtask

	// one broken header, chosen at random: the error is sticky so it closes the run
	task automatic send_bad_frame();
		logic [3:0]  op;
		logic [63:0] len64;
		op = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 5))
			0: send_byte({1'b1, 3'($urandom_range(1, 7)), op});
			1: begin
				send_byte({1'b1, 3'b000, op});
				send_byte({1'b0, 7'($urandom_range(0, 127))});
			end
			2: begin
				send_byte({1'b1, 4'b0000, op[2:0]});
				send_byte({1'b1, LEN7_EXT64});
				send_len(2, {39'd0, max_len} + 64'd1);
			end
			3: begin
				len64 = {$urandom, $urandom} | (64'd1 << CNT_W);
				send_byte({1'($urandom_range(0, 1)), 4'b0000, op[2:0]});
				send_byte({1'b1, LEN7_EXT64});
				send_len(2, len64);
			end
			4: begin
				send_byte({1'b1, 3'b000, 1'b1, op[2:0]});
				send_byte({1'b1, LEN7_EXT16});
				send_len(1, 64'($urandom_range(126, 65535)));
			end
			default: begin
				send_byte({1'b0, 3'b000, 1'b1, op[2:0]});
				send_byte({1'b1, 7'($urandom_range(0, 125))});
			end
		endcase
	endtask

	initial begin
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_wdata         <= '0;
		stream_if.valid   <= 1'b0;
		stream_if.rx_byte <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_word(dir_rows[i].data, '{dir_rows[i].pinned, dir_rows[i].has, dir_rows[i].res});
		while (words_sent < 400)
			send_frame();

		// nothing but empty frames pass with a zero limit
		set_max_payload('0);
		repeat (12) send_frame();

		set_max_payload(MAXP_RESET);
		while (words_sent < 900)
			send_frame();

		set_max_payload(MAXP_WIDTH'($urandom_range(1, 40)));
		while (words_sent < 1400)
			send_frame();

		set_max_payload(MAXP_WIDTH'($urandom_range(126, 300)));
		while (words_sent < 1950)
			send_frame();

		set_max_payload(($urandom_range(0, 1) == 0) ? MAXP_RESET :
			MAXP_WIDTH'($urandom_range(1, 300)));
		send_bad_frame();
		repeat (20) send_byte(8'($urandom));

		settle();
		repeat (8) @(posedge clk);
		if (fail_cnt == 0 && due_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
